// ===== rtl/csq_pkg.sv =====
// Types and constants of the C-SCAN disk request queue.
// Shared by the queue cell, the per-unit chain and the top level; no dependencies.
package csq_pkg;

    localparam int TAG_W    = 8;
    localparam int TRACK_W  = 10;
    localparam int SECTOR_W = 4;
    localparam int BUF_W    = 32;
    localparam int TCNT_W   = 11;
    localparam int OCC_W    = 6;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADTRK = 2'd3;

    localparam logic [TCNT_W-1:0] TRACK_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic                func;
        logic                unit;
        logic [TAG_W-1:0]    requester_tag;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] first_sector;
        logic [SECTOR_W-1:0] sector_count;
        logic                is_write;
        logic [BUF_W-1:0]    buffer_handle;
    } t_csq_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    out_tag;
        logic [TRACK_W-1:0]  out_track;
        logic [SECTOR_W-1:0] out_first_sector;
        logic [SECTOR_W-1:0] out_sector_count;
        logic                out_is_write;
        logic [BUF_W-1:0]    out_buffer_handle;
        logic [OCC_W-1:0]    queue_occupancy;
    } t_csq_out;

    // One queued request
    typedef struct packed {
        logic [TAG_W-1:0]    tag;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] first_sector;
        logic [SECTOR_W-1:0] sector_count;
        logic                is_write;
        logic [BUF_W-1:0]    buffer_handle;
    } t_csq_entry;

    // Command to every cell of one unit's chain
    typedef struct packed {
        logic enq;
        logic deq;
        logic asc;    // new track at or above the head track
    } t_csq_cmd;

    // Scan flags handed from one cell to the next
    typedef struct packed {
        logic all_ge;     // every entry so far is at or above the head track
        logic found;      // an entry so far stops the insertion scan
        logic at_or_past; // insertion point is at or before this cell
    } t_csq_link;

endpackage

// ===== rtl/csq_cell.sv =====
// One slot of a unit's request queue: holds an entry and works out its scan flags.
// Depends on csq_pkg.
module csq_cell (
    input  logic               i_clk,
    input  csq_pkg::t_csq_cmd  i_cmd,
    input  logic               i_is_head,
    input  logic               i_valid,
    input  logic [9:0]         i_head_track,
    input  logic [9:0]         i_new_track,
    input  csq_pkg::t_csq_entry i_new,
    input  csq_pkg::t_csq_entry i_prev,
    input  csq_pkg::t_csq_entry i_next,
    input  csq_pkg::t_csq_link i_link,
    output csq_pkg::t_csq_link o_link,
    output csq_pkg::t_csq_entry o_entry
);
    import csq_pkg::*;

    t_csq_entry r_entry;
    t_csq_entry n_entry;
    logic       w_ge;
    logic       w_lt;
    logic       w_all_ge;
    logic       w_stop;
    logic       w_found;

    // Compare this entry against the head and the new track
    assign w_ge     = (r_entry.track >= i_head_track);
    assign w_lt     = (r_entry.track < i_new_track);
    assign w_all_ge = i_link.all_ge && w_ge;
    assign w_stop   = !i_is_head &&
                      (i_cmd.asc ? !(w_ge && w_lt) : (!w_all_ge && !w_lt));
    assign w_found  = i_link.found || w_stop;

    // Hand the scan flags on
    always_comb begin
        o_link.all_ge     = w_all_ge;
        o_link.found      = w_found;
        o_link.at_or_past = !i_valid || w_found;
    end

    // Shift down on dequeue; on enqueue take the neighbor, load the new word, or hold
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.deq) begin
            n_entry = i_next;
        end else if (i_cmd.enq) begin
            if (i_link.at_or_past) begin
                n_entry = i_prev;
            end else if (o_link.at_or_past) begin
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/csq_chain.sv =====
// Request queue of one disk unit: a row of csq_cell slots and the fill count.
// Depends on csq_pkg and csq_cell.
module csq_chain #(
    parameter int DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_enq,
    input  logic                        i_deq,
    input  csq_pkg::t_csq_entry         i_entry,
    output csq_pkg::t_csq_entry         o_head,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);
    import csq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_csq_cmd      w_cmd;
    t_csq_entry    w_entry [DEPTH];
    t_csq_entry    w_prev  [DEPTH];
    t_csq_entry    w_next  [DEPTH];
    t_csq_link     w_link  [DEPTH+1];

    // Pick the run the new track joins
    always_comb begin
        w_cmd.enq = i_enq;
        w_cmd.deq = i_deq;
        w_cmd.asc = (i_entry.track >= w_entry[0].track);
    end

    // Scan starts with an empty prefix
    always_comb begin
        w_link[0].all_ge     = 1'b1;
        w_link[0].found      = 1'b0;
        w_link[0].at_or_past = 1'b0;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = i_entry;
        end else begin : g_mid
            assign w_prev[g] = w_entry[g-1];
        end
        if (g == DEPTH-1) begin : g_last
            assign w_next[g] = w_entry[g];
        end else begin : g_inner
            assign w_next[g] = w_entry[g+1];
        end

        csq_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_is_head    (g == 0),
            .i_valid      (r_count > CW'(g)),
            .i_head_track (w_entry[0].track),
            .i_new_track  (i_entry.track),
            .i_new        (i_entry),
            .i_prev       (w_prev[g]),
            .i_next       (w_next[g]),
            .i_link       (w_link[g]),
            .o_link       (w_link[g+1]),
            .o_entry      (w_entry[g])
        );
    end

    // Advance the fill count
    always_comb begin
        n_count = r_count;
        if (i_enq) begin
            n_count = r_count + CW'(1);
        end else if (i_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_entry[0];
    assign o_count = r_count;

endmodule

// ===== rtl/cscan_disk_request_queue.sv =====
// Top level of the C-SCAN disk request queue: command decode, status, result register.
// Depends on csq_pkg and csq_chain.
//
//  channel  | valid       | stall        | word
//  ---------+-------------+--------------+-------------------------------
//  request  | i_in_valid  | o_in_stall   | i_in_word  (csq_pkg::t_csq_in)
//  result   | o_out_valid | i_out_stall  | o_out_word (csq_pkg::t_csq_out)
//  config   | i_cfg_we    | -            | i_cfg_data (track count)
//
// One request per cycle while o_in_stall is low; its result is in the output register the next cycle.
// The cycle time is set by the insertion scan rippling through the row of cells.
// Reset clears fill counts and the result valid and sets track count to 1024.
// A held result stalls the request side unless it is taken in the same cycle.
module cscan_disk_request_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int UNIT_COUNT  = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  csq_pkg::t_csq_in                   i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output csq_pkg::t_csq_out                  o_out_word,
    input  logic                               i_cfg_we,
    input  logic [csq_pkg::TCNT_W-1:0]         i_cfg_data
);
    import csq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic [TCNT_W-1:0] r_track_count;
    logic              r_out_valid;
    t_csq_out          r_out;
    t_csq_out          n_out;
    logic              w_in_fire;
    t_csq_entry        w_new;
    t_csq_entry        w_head;
    logic [CW-1:0]     w_cnt;
    logic [CW-1:0]     w_cnt_after;
    logic              w_unit_ok;
    logic              w_enq_ok;
    logic              w_deq_ok;
    logic              w_enq   [UNIT_COUNT];
    logic              w_deq   [UNIT_COUNT];
    t_csq_entry        w_heads [UNIT_COUNT];
    logic [CW-1:0]     w_count [UNIT_COUNT];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_fire  = i_in_valid && !o_in_stall;

    // Pack the request word into a queue entry
    always_comb begin
        w_new.tag           = i_in_word.requester_tag;
        w_new.track         = i_in_word.track;
        w_new.first_sector  = i_in_word.first_sector;
        w_new.sector_count  = i_in_word.sector_count;
        w_new.is_write      = i_in_word.is_write;
        w_new.buffer_handle = i_in_word.buffer_handle;
    end

    // Select the addressed unit
    always_comb begin
        w_unit_ok = 1'b0;
        w_head    = w_heads[0];
        w_cnt     = w_count[0];
        for (int u = 0; u < UNIT_COUNT; u++) begin
            if (32'(i_in_word.unit) == u) begin
                w_unit_ok = 1'b1;
                w_head    = w_heads[u];
                w_cnt     = w_count[u];
            end
        end
    end

    // Decide status and build the result word
    always_comb begin
        w_enq_ok    = 1'b0;
        w_deq_ok    = 1'b0;
        w_cnt_after = w_cnt;
        n_out       = '0;
        if (!w_unit_ok) begin
            n_out.status = (i_in_word.func == FUNC_DEQ) ? ST_EMPTY : ST_FULL;
        end else if (i_in_word.func == FUNC_ENQ) begin
            if ({1'b0, i_in_word.track} >= r_track_count) begin
                n_out.status = ST_BADTRK;
            end else if (w_cnt == CW'(QUEUE_DEPTH)) begin
                n_out.status = ST_FULL;
            end else begin
                n_out.status = ST_OK;
                w_enq_ok     = 1'b1;
                w_cnt_after  = w_cnt + CW'(1);
            end
        end else begin
            if (w_cnt == '0) begin
                n_out.status = ST_EMPTY;
            end else begin
                n_out.status            = ST_OK;
                n_out.out_tag           = w_head.tag;
                n_out.out_track         = w_head.track;
                n_out.out_first_sector  = w_head.first_sector;
                n_out.out_sector_count  = w_head.sector_count;
                n_out.out_is_write      = w_head.is_write;
                n_out.out_buffer_handle = w_head.buffer_handle;
                w_deq_ok                = 1'b1;
                w_cnt_after             = w_cnt - CW'(1);
            end
        end
        if (w_unit_ok) begin
            n_out.queue_occupancy = OCC_W'(w_cnt_after);
        end
    end

    for (genvar u = 0; u < UNIT_COUNT; u++) begin : g_unit
        assign w_enq[u] = w_in_fire && w_enq_ok && (32'(i_in_word.unit) == u);
        assign w_deq[u] = w_in_fire && w_deq_ok && (32'(i_in_word.unit) == u);

        csq_chain #(
            .DEPTH (QUEUE_DEPTH)
        ) u_chain (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_enq   (w_enq[u]),
            .i_deq   (w_deq[u]),
            .i_entry (w_new),
            .o_head  (w_heads[u]),
            .o_count (w_count[u])
        );
    end

    // Hold the track count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= TRACK_COUNT_RST;
        end else if (i_cfg_we) begin
            r_track_count <= i_cfg_data;
        end
    end

    // Load the result register; drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Every accepted request yields a result the next cycle
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_out_valid)
        else $error("accepted request produced no result");

    // A failed operation returns no entry contents
    a_fail_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
        (r_out.out_tag == '0 && r_out.out_track == '0 && r_out.out_buffer_handle == '0))
        else $error("failed operation returned entry contents");

    // The first unit's fill count never passes the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count[0] <= CW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

endmodule
